### sv/alnum_vigenere_cipher_unit_assert.svh
// assertion macros for the cipher unit checker
`ifndef ALNUM_VIGENERE_CIPHER_UNIT_ASSERT_SVH
`define ALNUM_VIGENERE_CIPHER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define AVC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define AVC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/avc_pkg.sv
// shared types, constants and helper functions for the alphanumeric cipher unit
package avc_pkg;

    localparam int CHAR_W     = 8;
    localparam int SHIFT_W    = 5;
    localparam int KEY_LEN_W  = 6;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_NINE    = 8'h39;

    localparam logic [5:0] ALPHA_SIZE = 6'd26;
    localparam logic [4:0] DIGIT_SIZE = 5'd10;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_BYTES_0  = 3'd0,
        CFG_KEY_BYTES_1  = 3'd1,
        CFG_KEY_BYTES_2  = 3'd2,
        CFG_KEY_BYTES_3  = 3'd3,
        CFG_KEY_LENGTH   = 3'd4,
        CFG_DECRYPT_MODE = 3'd5
    } cfg_index_t;

    // control for one character transform
    typedef struct packed {
        logic               decrypt;
        logic [SHIFT_W-1:0] shift;
    } xform_ctrl_t;

    function automatic logic is_lower(input logic [CHAR_W-1:0] c);
        return (c >= ASCII_LOWER_A) && (c <= ASCII_LOWER_Z);
    endfunction

    function automatic logic is_upper(input logic [CHAR_W-1:0] c);
        return (c >= ASCII_UPPER_A) && (c <= ASCII_UPPER_Z);
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= ASCII_ZERO) && (c <= ASCII_NINE);
    endfunction

    // shift amount given by one key character
    function automatic logic [SHIFT_W-1:0] shift_of(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] diff;
        diff = '0;
        if (is_lower(c)) begin
            diff = c - ASCII_LOWER_A;
        end
        else if (is_upper(c)) begin
            diff = c - ASCII_UPPER_A;
        end
        else if (is_digit(c)) begin
            diff = c - ASCII_ZERO;
        end
        return diff[SHIFT_W-1:0];
    endfunction

endpackage

### sv/alnum_vigenere_cipher_unit.sv
// an accepted byte passes the input register, then the result register; one byte per cycle
// unless the result is stalled, set by the key position update done in the result stage
// a stalled result holds the result register; the input register still takes a byte if it
// is empty, and otherwise waits for the result register to free
// reset clears the key registers, key length, mode, key position and both valid flags
module alnum_vigenere_cipher_unit #(
    parameter int KEY_MAX = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // message byte channel
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic [avc_pkg::CHAR_W-1:0]          char_in,
    input  logic                                word_start,
    // result channel
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [avc_pkg::CHAR_W-1:0]          char_out,
    output logic                                key_error,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [avc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [avc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int PosW     = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int KeySlots = 1 << PosW;
    localparam int LenW     = avc_pkg::KEY_LEN_W;

    // configuration registers
    logic [avc_pkg::CFG_DATA_W-1:0] key_bytes_0_reg;
    logic [avc_pkg::CFG_DATA_W-1:0] key_bytes_1_reg;
    logic [avc_pkg::CFG_DATA_W-1:0] key_bytes_2_reg;
    logic [avc_pkg::CFG_DATA_W-1:0] key_bytes_3_reg;
    logic [LenW-1:0]                key_length_reg;
    logic                           decrypt_reg;

    // input stage
    logic                           s1_valid_reg;
    logic [avc_pkg::CHAR_W-1:0]     s1_char_reg;
    logic                           s1_word_reg;

    // result stage
    logic                           res_valid_reg;
    logic [avc_pkg::CHAR_W-1:0]     res_char_reg;
    logic                           res_err_reg;

    // key position
    logic [PosW-1:0]                key_position_reg;
    logic [PosW-1:0]                key_position_next;

    logic                           item_xfer;
    logic                           s1_advance;
    logic [4*avc_pkg::CFG_DATA_W-1:0] key_flat;
    logic [avc_pkg::CHAR_W-1:0]     key_chars [KeySlots];
    logic [LenW-1:0]                len_sat;
    logic                           len_zero;
    logic [PosW-1:0]                pos_base;
    logic [PosW-1:0]                pos_use;
    logic [LenW-1:0]                pos_inc;
    avc_pkg::xform_ctrl_t           xf_ctrl;
    logic [avc_pkg::CHAR_W-1:0]     xf_char;
    logic                           xf_alnum;
    logic [avc_pkg::CHAR_W-1:0]     res_char_next;

    // handshake
    assign cfg_ready    = 1'b1;
    assign s1_advance   = s1_valid_reg && (!res_valid_reg || !result_stall);
    assign item_stall   = s1_valid_reg && !s1_advance;
    assign item_xfer    = item_valid && !item_stall;
    assign result_valid = res_valid_reg;
    assign char_out     = res_char_reg;
    assign key_error    = res_err_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            key_bytes_0_reg <= '0;
            key_bytes_1_reg <= '0;
            key_bytes_2_reg <= '0;
            key_bytes_3_reg <= '0;
            key_length_reg  <= '0;
            decrypt_reg     <= 1'b0;
        end
        else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                avc_pkg::CFG_KEY_BYTES_0:  key_bytes_0_reg <= cfg_data;
                avc_pkg::CFG_KEY_BYTES_1:  key_bytes_1_reg <= cfg_data;
                avc_pkg::CFG_KEY_BYTES_2:  key_bytes_2_reg <= cfg_data;
                avc_pkg::CFG_KEY_BYTES_3:  key_bytes_3_reg <= cfg_data;
                avc_pkg::CFG_KEY_LENGTH:   key_length_reg  <= cfg_data[LenW-1:0];
                avc_pkg::CFG_DECRYPT_MODE: decrypt_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // key characters in position order
    assign key_flat = {key_bytes_3_reg, key_bytes_2_reg, key_bytes_1_reg, key_bytes_0_reg};

    always_comb
    begin
        for (int i = 0; i < KeySlots; i++) begin
            if (i < KEY_MAX) begin
                key_chars[i] = key_flat[i*avc_pkg::CHAR_W +: avc_pkg::CHAR_W];
            end
            else begin
                key_chars[i] = '0;
            end
        end
    end

    // effective key length and key position for the byte in the input stage
    assign len_sat  = (key_length_reg > LenW'(KEY_MAX)) ? LenW'(KEY_MAX) : key_length_reg;
    assign len_zero = (len_sat == '0);
    assign pos_base = s1_word_reg ? '0 : key_position_reg;
    assign pos_use  = (LenW'(pos_base) < len_sat) ? pos_base : '0;
    assign pos_inc  = LenW'(pos_use) + LenW'(1);

    assign xf_ctrl.decrypt = decrypt_reg;
    assign xf_ctrl.shift   = avc_pkg::shift_of(key_chars[pos_use]);

    avc_char_xform u_xform (
        .char_in  (s1_char_reg),
        .ctrl     (xf_ctrl),
        .char_out (xf_char),
        .alnum    (xf_alnum)
    );

    // next key position: restart at zero on a word start, advance on letters and digits, wrap at the key length
    always_comb
    begin
        key_position_next = pos_base;
        if (!len_zero && xf_alnum) begin
            key_position_next = (pos_inc >= len_sat) ? '0 : PosW'(pos_inc);
        end
    end

    assign res_char_next = len_zero ? s1_char_reg : xf_char;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg     <= 1'b0;
            res_valid_reg    <= 1'b0;
            key_position_reg <= '0;
        end
        else begin
            if (item_xfer) begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance) begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_advance) begin
                res_valid_reg    <= 1'b1;
                key_position_reg <= key_position_next;
            end
            else if (!result_stall) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_xfer) begin
            s1_char_reg <= char_in;
            s1_word_reg <= word_start;
        end
        if (s1_advance) begin
            res_char_reg <= res_char_next;
            res_err_reg  <= len_zero;
        end
    end

endmodule

### sv/avc_char_xform.sv
// per-character shift: letters modulo 26 keeping case, digits modulo 10
module avc_char_xform (
    input  logic [avc_pkg::CHAR_W-1:0] char_in,
    input  avc_pkg::xform_ctrl_t       ctrl,
    output logic [avc_pkg::CHAR_W-1:0] char_out,
    output logic                       alnum
);

    logic                          lower;
    logic                          upper;
    logic                          digit;
    logic [avc_pkg::CHAR_W-1:0]    base;
    logic [avc_pkg::CHAR_W-1:0]    offset;
    logic [5:0]                    let_v;
    logic [5:0]                    let_k;
    logic [5:0]                    let_sum;
    logic [5:0]                    let_res;
    logic [4:0]                    dig_v;
    logic [4:0]                    dig_k;
    logic [4:0]                    dig_sum;
    logic [4:0]                    dig_res;

    assign lower = avc_pkg::is_lower(char_in);
    assign upper = avc_pkg::is_upper(char_in);
    assign digit = avc_pkg::is_digit(char_in);
    assign alnum = lower | upper | digit;

    // alphabet base of the message character
    always_comb
    begin
        if (digit) begin
            base = avc_pkg::ASCII_ZERO;
        end
        else if (lower) begin
            base = avc_pkg::ASCII_LOWER_A;
        end
        else begin
            base = avc_pkg::ASCII_UPPER_A;
        end
    end

    assign offset = char_in - base;

    // letter path, one add or subtract and one correction
    assign let_v   = {1'b0, offset[4:0]};
    assign let_k   = {1'b0, ctrl.shift};
    assign let_sum = let_v + let_k;

    always_comb
    begin
        if (ctrl.decrypt) begin
            let_res = (let_v < let_k) ? (let_v + avc_pkg::ALPHA_SIZE - let_k)
                                      : (let_v - let_k);
        end
        else begin
            let_res = (let_sum >= avc_pkg::ALPHA_SIZE) ? (let_sum - avc_pkg::ALPHA_SIZE)
                                                       : let_sum;
        end
    end

    // digit path, key shift first folded below ten for shifts up to 29
    assign dig_v = {1'b0, offset[3:0]};

    always_comb
    begin
        if (ctrl.shift >= 5'd20) begin
            dig_k = ctrl.shift - 5'd20;
        end
        else if (ctrl.shift >= avc_pkg::DIGIT_SIZE) begin
            dig_k = ctrl.shift - avc_pkg::DIGIT_SIZE;
        end
        else begin
            dig_k = ctrl.shift;
        end
    end

    assign dig_sum = dig_v + dig_k;

    always_comb
    begin
        if (ctrl.decrypt) begin
            dig_res = (dig_v < dig_k) ? (dig_v + avc_pkg::DIGIT_SIZE - dig_k)
                                      : (dig_v - dig_k);
        end
        else begin
            dig_res = (dig_sum >= avc_pkg::DIGIT_SIZE) ? (dig_sum - avc_pkg::DIGIT_SIZE)
                                                       : dig_sum;
        end
    end

    // rebuild the character, others pass unchanged
    always_comb
    begin
        if (digit) begin
            char_out = base + {3'b000, dig_res};
        end
        else if (lower | upper) begin
            char_out = base + {2'b00, let_res};
        end
        else begin
            char_out = char_in;
        end
    end

endmodule

### sv/avc_checker.sv
// port-level checker for the cipher unit, bound to the top level
`include "alnum_vigenere_cipher_unit_assert.svh"

module avc_checker (
    input logic clk,
    input logic rst_n,
    input logic item_valid,
    input logic item_stall,
    input logic result_valid,
    input logic result_stall,
    input logic [7:0] char_out,
    input logic key_error
);

    // a stalled result stays and holds its payload
    `AVC_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(char_out) && $stable(key_error), "stalled result changed")

    // the input side only waits behind a stalled result
    `AVC_ASSERT_NOW(a_stall_cause, item_stall, result_valid && result_stall, "input stalled without a stalled result")

    // an accepted byte shows up as a result after passing the input register and the result register
    `AVC_ASSERT_NEXT(a_result_follows, item_valid && !item_stall, ##1 result_valid, "accepted byte gave no result")

endmodule

bind alnum_vigenere_cipher_unit avc_checker u_avc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .char_out     (char_out),
    .key_error    (key_error)
);
